[sv/swmf_pkg.sv]
// Package: shared constants, register codes, control struct and tree sizing.
`default_nettype none
package swmf_pkg;

	localparam int MAX_WINDOW_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 32;
	localparam int LEN_BITS        = 7;
	localparam int APB_DATA_BITS   = 32;
	localparam int APB_ADDR_BITS   = 3;

	localparam logic [LEN_BITS-1:0] WINDOW_LEN_RESET = 7'd1;

	// Register index, taken from the word address bit.
	typedef enum logic {
		REG_WINDOW_LEN = 1'b0
	} swmf_reg_t;

	// Control that travels forward with each pipeline transaction.
	typedef struct packed {
		logic valid;
		logic last;
	} swmf_ctl_t;

	// Number of four-to-one reduction stages needed to cover n leaves.
	function automatic int tree_stages(input int n);
		int s;
		int span;
		s = 0;
		span = 1;
		while (span < n) begin
			span = span * 4;
			s = s + 1;
		end
		return s;
	endfunction

endpackage
`default_nettype wire

[sv/swmf_cfg.sv]
// Configuration register file: window length register and its clamped form.
`default_nettype none
module swmf_cfg #(
	parameter int MAX_WINDOW = swmf_pkg::MAX_WINDOW_DEF,
	parameter int CNT_W      = $clog2(MAX_WINDOW + 1)
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [swmf_pkg::APB_ADDR_BITS-1:0] paddr,
	input  wire logic [swmf_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic      [swmf_pkg::APB_DATA_BITS-1:0] prdata,
	output logic      [CNT_W-1:0]                   eff_len
);

	localparam int CMP_W = (CNT_W > swmf_pkg::LEN_BITS) ? CNT_W : swmf_pkg::LEN_BITS;

	logic [swmf_pkg::LEN_BITS-1:0] len_q;
	swmf_pkg::swmf_reg_t           reg_sel;
	logic                          wr_en;
	logic [CMP_W-1:0]              len_x;
	logic [CMP_W-1:0]              max_x;

	assign reg_sel = swmf_pkg::swmf_reg_t'(paddr[2]);
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= swmf_pkg::WINDOW_LEN_RESET;
		end else if (wr_en && reg_sel == swmf_pkg::REG_WINDOW_LEN) begin
			len_q <= pwdata[swmf_pkg::LEN_BITS-1:0];
		end
	end

	always_comb begin
		unique case (reg_sel)
			swmf_pkg::REG_WINDOW_LEN: begin
				prdata = {{(swmf_pkg::APB_DATA_BITS - swmf_pkg::LEN_BITS){1'b0}}, len_q};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	// A zero length acts as one; lengths beyond the window store saturate.
	assign len_x = CMP_W'(len_q);
	assign max_x = CMP_W'(MAX_WINDOW);

	always_comb begin
		if (len_x == '0) begin
			eff_len = CNT_W'(1);
		end else if (len_x > max_x) begin
			eff_len = CNT_W'(max_x);
		end else begin
			eff_len = CNT_W'(len_x);
		end
	end

endmodule
`default_nettype wire

[sv/swmf_window.sv]
// Window stage: sample shift line, fill count and masking of the tree leaves.
`default_nettype none
module swmf_window #(
	parameter int MAX_WINDOW  = swmf_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF,
	parameter int CNT_W       = $clog2(MAX_WINDOW + 1),
	parameter int LEAVES      = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	input  wire logic                          first_of_array,
	input  wire logic                          last_of_array,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic        [CNT_W-1:0]       eff_len,
	output swmf_pkg::swmf_ctl_t                out_ctl,
	input  wire logic                          out_ready,
	output logic [SAMPLE_BITS*LEAVES-1:0]      leaves
);

	localparam logic [SAMPLE_BITS-1:0] INT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic signed [SAMPLE_BITS-1:0] taps_s1 [MAX_WINDOW];
	logic [CNT_W-1:0]              len_s1;
	swmf_pkg::swmf_ctl_t           ctl_s1;
	logic [CNT_W-1:0]              fill_q;
	logic [CNT_W-1:0]              fill_base;
	logic [CNT_W-1:0]              fill_next;
	logic                          produce;
	logic                          accept;

	assign in_ready = !ctl_s1.valid || out_ready;
	assign accept   = in_valid && in_ready;
	assign out_ctl  = ctl_s1;

	always_comb begin
		fill_base = first_of_array ? '0 : fill_q;
		if (fill_base < CNT_W'(MAX_WINDOW)) begin
			fill_next = CNT_W'(fill_base + 1'b1);
		end else begin
			fill_next = fill_base;
		end
		produce = (fill_next >= eff_len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ctl_s1 <= '0;
		end else if (accept) begin
			// The last element of an array closes it, so the next sample starts afresh.
			fill_q       <= last_of_array ? '0 : fill_next;
			ctl_s1.valid <= produce;
			ctl_s1.last  <= last_of_array;
		end else if (out_ready) begin
			ctl_s1.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			taps_s1[0] <= sample;
			for (int k = 1; k < MAX_WINDOW; k++) begin
				taps_s1[k] <= taps_s1[k-1];
			end
			len_s1 <= eff_len;
		end
	end

	// Taps beyond the window length, and padding leaves, never win the maximum.
	always_comb begin
		leaves = {LEAVES{INT_MIN}};
		for (int k = 0; k < MAX_WINDOW; k++) begin
			if (k < int'(len_s1)) begin
				leaves[k*SAMPLE_BITS +: SAMPLE_BITS] = taps_s1[k];
			end
		end
	end

endmodule
`default_nettype wire

[sv/swmf_reduce.sv]
// Reduction stage: two comparator levels, four lanes into one, with a stage register.
`default_nettype none
module swmf_reduce #(
	parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF,
	parameter int N_IN        = 64,
	parameter int LANES       = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire swmf_pkg::swmf_ctl_t        in_ctl,
	output logic                            in_ready,
	input  wire logic [SAMPLE_BITS*LANES-1:0] din,
	output swmf_pkg::swmf_ctl_t             out_ctl,
	input  wire logic                       out_ready,
	output logic [SAMPLE_BITS*LANES-1:0]    dout
);

	localparam int N_OUT = N_IN / 4;

	logic signed [SAMPLE_BITS-1:0] lane_in [N_IN];
	logic signed [SAMPLE_BITS-1:0] max_d   [N_OUT];
	logic signed [SAMPLE_BITS-1:0] max_q   [N_OUT];
	swmf_pkg::swmf_ctl_t           ctl_q;
	logic                          load;

	assign in_ready = !ctl_q.valid || out_ready;
	assign load     = in_ctl.valid && in_ready;
	assign out_ctl  = ctl_q;

	always_comb begin
		logic signed [SAMPLE_BITS-1:0] pair_a;
		logic signed [SAMPLE_BITS-1:0] pair_b;
		for (int i = 0; i < N_IN; i++) begin
			lane_in[i] = din[i*SAMPLE_BITS +: SAMPLE_BITS];
		end
		for (int j = 0; j < N_OUT; j++) begin
			pair_a   = (lane_in[4*j+1] > lane_in[4*j])   ? lane_in[4*j+1] : lane_in[4*j];
			pair_b   = (lane_in[4*j+3] > lane_in[4*j+2]) ? lane_in[4*j+3] : lane_in[4*j+2];
			max_d[j] = (pair_b > pair_a) ? pair_b : pair_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (load) begin
			ctl_q <= in_ctl;
		end else if (out_ready) begin
			ctl_q.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int j = 0; j < N_OUT; j++) begin
				max_q[j] <= max_d[j];
			end
		end
	end

	always_comb begin
		dout = '0;
		for (int j = 0; j < N_OUT; j++) begin
			dout[j*SAMPLE_BITS +: SAMPLE_BITS] = max_q[j];
		end
	end

endmodule
`default_nettype wire

[sv/sliding_window_max_filter_unit.sv]
// Top level: sliding window maximum filter with APB configuration.
//
//   Channel   Direction  Handshake                     Payload
//   sample    in         sample_valid / sample_ready   sample, first_of_array, last_of_array
//   result    out        result_valid / result_ready   window_max, end_of_array
//   config    in         APB (psel, penable, pready)   window_len at byte address 0
//
// One sample is taken every cycle unless the pipeline stalls. A result passes the window register, then
// one register in each of S four-to-one comparator stages over the window taps (3 for 64).
// Every stage has its own register, so a full pipeline stalls only from its tail and
// bubbles close up; the shift line holds still while its stage is blocked.
// Reset clears the fill count, the valid bits and the window length (to 1); the shift line
// has no reset and is read only where the current array has written it.
`default_nettype none
module sliding_window_max_filter_unit #(
	parameter int MAX_WINDOW  = swmf_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic signed [SAMPLE_BITS-1:0]      sample,
	input  wire logic                               first_of_array,
	input  wire logic                               last_of_array,
	input  wire logic                               sample_valid,
	output logic                                    sample_ready,
	output logic signed [SAMPLE_BITS-1:0]           window_max,
	output logic                                    end_of_array,
	output logic                                    result_valid,
	input  wire logic                               result_ready,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [swmf_pkg::APB_ADDR_BITS-1:0] paddr,
	input  wire logic [swmf_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic      [swmf_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                                    pready
);

	localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
	localparam int NSTG   = swmf_pkg::tree_stages(MAX_WINDOW);
	localparam int LEAVES = 1 << (2 * NSTG);

	logic [CNT_W-1:0]              eff_len;
	logic [SAMPLE_BITS*LEAVES-1:0] lvl [NSTG+1];
	swmf_pkg::swmf_ctl_t           ctl [NSTG+1];
	logic                          rdy [NSTG+1];

	assign pready = 1'b1;

	swmf_cfg #(
		.MAX_WINDOW (MAX_WINDOW),
		.CNT_W      (CNT_W)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.eff_len (eff_len)
	);

	swmf_window #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS),
		.CNT_W       (CNT_W),
		.LEAVES      (LEAVES)
	) u_window (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample         (sample),
		.first_of_array (first_of_array),
		.last_of_array  (last_of_array),
		.in_valid       (sample_valid),
		.in_ready       (sample_ready),
		.eff_len        (eff_len),
		.out_ctl        (ctl[0]),
		.out_ready      (rdy[0]),
		.leaves         (lvl[0])
	);

	for (genvar g = 0; g < NSTG; g++) begin : g_tree
		swmf_reduce #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.N_IN        (LEAVES >> (2 * g)),
			.LANES       (LEAVES)
		) u_reduce (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_ctl    (ctl[g]),
			.in_ready  (rdy[g]),
			.din       (lvl[g]),
			.out_ctl   (ctl[g+1]),
			.out_ready (rdy[g+1]),
			.dout      (lvl[g+1])
		);
	end

	assign rdy[NSTG]    = result_ready;
	assign result_valid = ctl[NSTG].valid;
	assign end_of_array = ctl[NSTG].last;
	assign window_max   = lvl[NSTG][SAMPLE_BITS-1:0];

endmodule
`default_nettype wire

[test/testbench.sv]
// Testbench for the sliding window maximum filter: directed and random arrays checked against a predictor.
`default_nettype none
module testbench;
	import swmf_pkg::*;

	localparam int HALF_PERIOD    = 4;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 10;
	localparam int HOLD_CYCLES    = 60;

	typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;
	typedef logic [LEN_BITS-1:0] window_len_t;

	typedef struct packed {
		sample_t window_max;
		logic    end_of_array;
	} window_result_t;

	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS_DEF-1){1'b0}}};
	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS_DEF-1){1'b1}}};

	logic clk = 1'b0;
	logic arst_n;
	sample_t sample;
	logic first_of_array;
	logic last_of_array;
	logic sample_valid;
	logic sample_ready;
	sample_t window_max;
	logic end_of_array;
	logic result_valid;
	logic result_ready;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic pready;

	// Predictor state.
	sample_t window_history [MAX_WINDOW_DEF];
	int unsigned fill_level = 0;
	int unsigned write_slot = 0;
	window_len_t cur_window_len = WINDOW_LEN_RESET;
	window_result_t pending_maxima [$];

	int errors = 0;
	int quiet_cycles = 0;
	int samples_sent = 0;
	bit sender_idle = 1'b1;
	bit receiver_idle = 1'b1;
	bit hold_request = 1'b0;

	sliding_window_max_filter_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample         (sample),
		.first_of_array (first_of_array),
		.last_of_array  (last_of_array),
		.sample_valid   (sample_valid),
		.sample_ready   (sample_ready),
		.window_max     (window_max),
		.end_of_array   (end_of_array),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	function automatic int unsigned effective_span(input window_len_t len);
		if (len == 0)
			return 1;
		if (len > MAX_WINDOW_DEF)
			return MAX_WINDOW_DEF;
		return len;
	endfunction

	function automatic int pick_gap(input bit enabled);
		int r;
		r = $urandom_range(0, 19);
		if (!enabled || r < 10)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic sample_t pick_sample();
		int mode;
		mode = $urandom_range(0, 9);
		if (mode < 5)
			return sample_t'($urandom);
		if (mode < 8)
			return sample_t'($urandom_range(0, 16)) - sample_t'(8);
		case ($urandom_range(0, 3))
			0: return SAMPLE_MIN;
			1: return SAMPLE_MAX;
			2: return sample_t'(0);
			default: return sample_t'(-1);
		endcase
	endfunction

	// Updates the predictor with one accepted sample and queues the maximum it yields, if any.
	task automatic predict_window_max(input sample_t value, input logic first, input logic last);
		int unsigned span;
		int unsigned slot;
		sample_t peak;
		window_result_t res;
		span = effective_span(cur_window_len);
		if (first)
			fill_level = 0;
		window_history[write_slot] = value;
		write_slot = (write_slot + 1) % MAX_WINDOW_DEF;
		if (fill_level < MAX_WINDOW_DEF)
			fill_level++;
		if (fill_level >= span) begin
			peak = value;
			for (int unsigned k = 1; k < span; k++) begin
				slot = (write_slot + MAX_WINDOW_DEF - 1 - k) % MAX_WINDOW_DEF;
				if (window_history[slot] > peak)
					peak = window_history[slot];
			end
			res.window_max = peak;
			res.end_of_array = last;
			pending_maxima = {pending_maxima, res};
		end
		if (last)
			fill_level = 0;
	endtask

	// Called at a rising edge; returns at the edge where the transaction is accepted.
	// Valid stays high afterwards so that a following item can go out back to back.
	task automatic send_sample(input sample_t value, input logic first, input logic last);
		int gap;
		gap = pick_gap(sender_idle);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample <= value;
		first_of_array <= first;
		last_of_array <= last;
		sample_valid <= 1'b1;
		do @(posedge clk); while (!sample_ready);
		predict_window_max(value, first, last);
		samples_sent++;
	endtask

	task automatic wait_idle();
		sample_valid <= 1'b0;
		while (pending_maxima.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_window_len(input window_len_t len);
		wait_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_WINDOW_LEN, 2'b00};
		pwdata <= APB_DATA_BITS'(len);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_window_len = len;
	endtask

	// Mostly well-formed arrays at least one window long, some short ones, and stray flags.
	task automatic send_random_array(input int unsigned span);
		int unsigned count;
		int r;
		bit opens;
		bit closes;
		logic first;
		logic last;
		r = $urandom_range(0, 9);
		if (r < 7)
			count = span + $urandom_range(0, 6);
		else if (r < 9)
			count = $urandom_range(1, span);
		else
			count = $urandom_range(1, 4);
		opens = ($urandom_range(0, 9) != 0);
		closes = ($urandom_range(0, 9) != 0);
		for (int unsigned i = 0; i < count; i++) begin
			first = (i == 0 && opens) || ($urandom_range(0, 39) == 0);
			last = (i == count - 1 && closes) || ($urandom_range(0, 39) == 0);
			send_sample(pick_sample(), first, last);
		end
	endtask

	task automatic test_extreme_samples();
		set_window_len(7'd1);
		send_sample(SAMPLE_MIN, 1'b1, 1'b0);
		send_sample(SAMPLE_MAX, 1'b0, 1'b0);
		send_sample(sample_t'(0), 1'b0, 1'b0);
		send_sample(sample_t'(-1), 1'b0, 1'b0);
		send_sample(SAMPLE_MIN + sample_t'(1), 1'b0, 1'b1);
	endtask

	task automatic test_short_arrays();
		send_sample(sample_t'(42), 1'b1, 1'b1);
		set_window_len(7'd3);
		send_sample(sample_t'(-7), 1'b1, 1'b1);
		send_sample(SAMPLE_MAX, 1'b1, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0, 1'b1);
	endtask

	// The second array opens without a first flag; the last flag of the one before restarts it.
	task automatic test_missing_first_flag();
		send_sample(sample_t'(5), 1'b1, 1'b0);
		send_sample(sample_t'(-5), 1'b0, 1'b0);
		send_sample(sample_t'(3), 1'b0, 1'b1);
		send_sample(sample_t'(-100), 1'b0, 1'b0);
		send_sample(sample_t'(-200), 1'b0, 1'b0);
		send_sample(sample_t'(-300), 1'b0, 1'b1);
	endtask

	// A longer window set in the middle of an array holds results back until it is filled.
	task automatic test_window_change_in_array();
		set_window_len(7'd2);
		send_sample(SAMPLE_MIN, 1'b1, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0, 1'b0);
		send_sample(SAMPLE_MAX, 1'b0, 1'b0);
		set_window_len(7'd5);
		send_sample(sample_t'(-1), 1'b0, 1'b0);
		send_sample(sample_t'(0), 1'b0, 1'b1);
	endtask

	task automatic test_zero_window_len();
		set_window_len(7'd0);
		send_sample(sample_t'(9), 1'b1, 1'b0);
		send_sample(sample_t'(-9), 1'b0, 1'b1);
	endtask

	task automatic test_random_arrays(input window_len_t len, input int quota,
			input bit s_idle, input bit r_idle);
		int start;
		set_window_len(len);
		sender_idle = s_idle;
		receiver_idle = r_idle;
		start = samples_sent;
		while (samples_sent - start < quota)
			send_random_array(effective_span(len));
	endtask

	// The sink holds off for a long stretch while samples keep coming, so the pipeline fills.
	task automatic test_result_backpressure();
		int start;
		set_window_len(7'd4);
		sender_idle = 1'b0;
		receiver_idle = 1'b0;
		hold_request = 1'b1;
		start = samples_sent;
		while (samples_sent - start < 40)
			send_random_array(4);
	endtask

	initial begin : result_sink
		int stall;
		int r;
		result_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			stall = 0;
			if (hold_request) begin
				hold_request = 1'b0;
				stall = HOLD_CYCLES;
			end else if (receiver_idle && $urandom_range(0, 3) == 0) begin
				r = $urandom_range(0, 9);
				if (r < 7)
					stall = $urandom_range(1, 2);
				else if (r < 9)
					stall = $urandom_range(3, 6);
				else
					stall = $urandom_range(10, 30);
			end
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_check
		window_result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_maxima.size() == 0) begin
				$display("%0t: unexpected result, window_max %0d end_of_array %0b",
					$time, window_max, end_of_array);
				errors++;
			end else begin
				want = pending_maxima.pop_front();
				if (want.window_max !== window_max) begin
					$display("%0t: window_max expected %0d actual %0d",
						$time, want.window_max, window_max);
					errors++;
				end
				if (want.end_of_array !== end_of_array) begin
					$display("%0t: end_of_array expected %0b actual %0b",
						$time, want.end_of_array, end_of_array);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		sample <= '0;
		first_of_array <= 1'b0;
		last_of_array <= 1'b0;
		sample_valid <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extreme_samples();
		test_short_arrays();
		test_missing_first_flag();
		test_window_change_in_array();
		test_zero_window_len();

		test_random_arrays(7'd1, 30, 1'b1, 1'b1);
		test_random_arrays(7'd2, 30, 1'b0, 1'b0);
		test_random_arrays(7'd3, 30, 1'b1, 1'b1);
		test_random_arrays(7'd5, 30, 1'b1, 1'b0);
		test_random_arrays(7'd8, 30, 1'b0, 1'b1);
		test_random_arrays(7'd16, 40, 1'b1, 1'b1);
		test_random_arrays(7'd64, 60, 1'b1, 1'b1);
		test_random_arrays(7'd127, 40, 1'b0, 1'b0);
		test_random_arrays(7'd0, 30, 1'b1, 1'b1);
		test_random_arrays(window_len_t'($urandom_range(1, MAX_WINDOW_DEF)), 40, 1'b1, 1'b1);
		test_result_backpressure();

		wait_idle();
		if (errors == 0 && pending_maxima.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire

[files.f]
sv/swmf_pkg.sv
sv/swmf_cfg.sv
sv/swmf_window.sv
sv/swmf_reduce.sv
sv/sliding_window_max_filter_unit.sv
test/testbench.sv
